FILE: rtl/skf_pkg.sv
// Shared constants, widths and status types of the scalar Kalman filter.
`default_nettype none
package skf_pkg;

	// Field and fixed-point widths
	localparam int GAIN_FRAC_BITS = 24;
	localparam int DATA_W         = 32;
	localparam int GW             = GAIN_FRAC_BITS + 1;
	localparam int CNT_W          = $clog2(GW + 1);
	localparam int NUM_W          = DATA_W + GAIN_FRAC_BITS + 1;
	localparam int MC_W           = DATA_W + 2;
	localparam int ADDR_W         = 3;

	// Reset values
	localparam logic [DATA_W-1:0] PN_RESET  = 32'd3774874;
	localparam logic [DATA_W-1:0] MN_RESET  = 32'd7130317;
	localparam logic [DATA_W-1:0] COV_RESET = DATA_W'(1) << GAIN_FRAC_BITS;

	// Gain of one and the rounding half for the low product bits
	localparam logic [GW-1:0] GAIN_ONE = GW'(1) << GAIN_FRAC_BITS;
	localparam logic [GW:0]   RND_HALF = (GW + 1)'(1) << (GAIN_FRAC_BITS - 1);

	// Register indexes
	typedef enum logic {
		REG_PROCESS_NOISE = 1'b0,
		REG_MEASURE_NOISE = 1'b1
	} reg_idx_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic          done;
		logic [GW-1:0] quot;
	} div_res_t;

	// Multiplier status toward the sequencer
	typedef struct packed {
		logic                   done;
		logic signed [MC_W-1:0] hi;
		logic [GW-1:0]          lo;
	} mul_res_t;

endpackage
`default_nettype wire

FILE: rtl/skf_div.sv
// Bit-serial restoring divider that forms the rounded Kalman gain quotient.
`default_nettype none
module skf_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [skf_pkg::DATA_W-1:0]       pred,
	input  wire logic [skf_pkg::DATA_W:0]         sum,
	output skf_pkg::div_res_t                     res
);

	logic [skf_pkg::DATA_W:0]      rem_q;
	logic [skf_pkg::DATA_W:0]      sum_q;
	logic [skf_pkg::GW-1:0]        lo_q;
	logic [skf_pkg::GW-1:0]        quot_q;
	logic [skf_pkg::CNT_W-1:0]     cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [skf_pkg::NUM_W-1:0]     num;
	logic [skf_pkg::DATA_W+1:0]    sh;
	logic [skf_pkg::DATA_W+2:0]    diff;
	logic                          ge;

	// Numerator: pred scaled by the gain fraction plus half the divisor
	assign num = {1'b0, pred, {skf_pkg::GAIN_FRAC_BITS{1'b0}}}
		+ skf_pkg::NUM_W'(sum[skf_pkg::DATA_W:1]);

	// One trial subtract per cycle
	assign sh   = {rem_q, lo_q[skf_pkg::GW-1]};
	assign diff = {1'b0, sh} - {2'b00, sum_q};
	assign ge   = ~diff[skf_pkg::DATA_W+2];

	// Load, then shift in one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= skf_pkg::CNT_W'(skf_pkg::GW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == skf_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num[skf_pkg::NUM_W-1:skf_pkg::GW]};
			lo_q   <= num[skf_pkg::GW-1:0];
			quot_q <= '0;
			sum_q  <= sum;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[skf_pkg::DATA_W:0] : sh[skf_pkg::DATA_W:0];
			lo_q   <= {lo_q[skf_pkg::GW-2:0], 1'b0};
			quot_q <= {quot_q[skf_pkg::GW-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;

endmodule
`default_nettype wire

FILE: rtl/skf_mul.sv
// Bit-serial shift-add multiplier: signed multiplicand times unsigned gain-width multiplier.
`default_nettype none
module skf_mul (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [skf_pkg::MC_W-1:0]   mcand,
	input  wire logic [skf_pkg::GW-1:0]            mplier,
	output skf_pkg::mul_res_t                      res
);

	logic signed [skf_pkg::MC_W-1:0] hi_q;
	logic signed [skf_pkg::MC_W-1:0] mc_q;
	logic [skf_pkg::GW-1:0]          lo_q;
	logic [skf_pkg::GW-1:0]          m_q;
	logic [skf_pkg::CNT_W-1:0]       cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic signed [skf_pkg::MC_W:0]   addend;
	logic signed [skf_pkg::MC_W:0]   t;

	// Add the multiplicand when the low multiplier bit is set
	assign addend = m_q[0] ? {mc_q[skf_pkg::MC_W-1], mc_q} : '0;
	assign t      = {hi_q[skf_pkg::MC_W-1], hi_q} + addend;

	// Count the multiplier bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= skf_pkg::CNT_W'(skf_pkg::GW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == skf_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the partial product right one bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= '0;
			lo_q <= '0;
			mc_q <= mcand;
			m_q  <= mplier;
		end else if (busy_q) begin
			hi_q <= t[skf_pkg::MC_W:1];
			lo_q <= {t[0], lo_q[skf_pkg::GW-1:1]};
			m_q  <= {1'b0, m_q[skf_pkg::GW-1:1]};
		end
	end

	assign res.done = done_q;
	assign res.hi   = hi_q;
	assign res.lo   = lo_q;

endmodule
`default_nettype wire

FILE: rtl/scalar_kalman_filter_unit.sv
// Each accepted sample runs through the bit-serial divider (25 quotient bits) and then
// the two bit-serial multipliers (25 bits, run together). A new sample is taken only
// when idle, after write-back; write-back waits while a pending output is not taken.
// Reset: estimate 0, covariance 1.0, noise registers to their defaults, no output pending.
// Top level: APB registers, sequencer and update arithmetic of the scalar Kalman filter.
`default_nettype none
module scalar_kalman_filter_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Sample channel
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [skf_pkg::DATA_W-1:0]  sample,
	// Estimate channel
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [skf_pkg::DATA_W-1:0]       estimate_out,
	// Register port
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [skf_pkg::ADDR_W-1:0]         paddr,
	input  wire logic [skf_pkg::DATA_W-1:0]         pwdata,
	output logic [skf_pkg::DATA_W-1:0]              prdata,
	output logic                                    pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_MSTART,
		ST_MUL,
		ST_FIN
	} state_t;

	localparam int DW = skf_pkg::DATA_W;
	localparam int G  = skf_pkg::GAIN_FRAC_BITS;
	localparam int GW = skf_pkg::GW;
	localparam int MW = skf_pkg::MC_W;

	state_t                    state_q;
	logic [DW-1:0]             pn_q;
	logic [DW-1:0]             mn_q;
	logic signed [DW-1:0]      est_q;
	logic [DW-1:0]             cov_q;
	logic [DW-1:0]             pred_q;
	logic signed [DW:0]        innov_q;
	logic [GW-1:0]             gain_q;
	logic                      zero_q;
	logic                      out_valid_q;

	logic                      wr_en;
	skf_pkg::reg_idx_t         widx;
	logic [DW:0]               pred_sum;
	logic [DW-1:0]             pred_sat;
	logic [DW:0]               den;
	logic signed [DW:0]        innov;
	skf_pkg::div_res_t         div_res;
	skf_pkg::mul_res_t         est_res;
	skf_pkg::mul_res_t         cov_res;
	logic [GW:0]               est_lo_rnd;
	logic [GW:0]               cov_lo_rnd;
	logic signed [MW:0]        delta;
	logic signed [MW:0]        cov_rnd;
	logic signed [MW+1:0]      nx;
	logic signed [DW-1:0]      nx_sat;
	logic [DW-1:0]             cov_next;
	logic                      in_acc;
	logic                      fin_go;

	// Register port
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign widx   = skf_pkg::reg_idx_t'(paddr[2]);
	assign prdata = (widx == skf_pkg::REG_MEASURE_NOISE) ? mn_q : pn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pn_q <= skf_pkg::PN_RESET;
			mn_q <= skf_pkg::MN_RESET;
		end else if (wr_en) begin
			case (widx)
				skf_pkg::REG_PROCESS_NOISE: pn_q <= pwdata;
				skf_pkg::REG_MEASURE_NOISE: mn_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Predicted covariance, saturated, and innovation at accept
	assign pred_sum = {1'b0, cov_q} + {1'b0, pn_q};
	assign pred_sat = pred_sum[DW] ? '1 : pred_sum[DW-1:0];
	assign innov    = {sample[DW-1], sample} - {est_q[DW-1], est_q};

	// Gain denominator
	assign den = {1'b0, pred_q} + {1'b0, mn_q};

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid & in_ready;

	skf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_PREP),
		.pred   (pred_q),
		.sum    (den),
		.res    (div_res)
	);

	skf_mul u_mul_est (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_MSTART),
		.mcand  ({innov_q[DW], innov_q}),
		.mplier (gain_q),
		.res    (est_res)
	);

	skf_mul u_mul_cov (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_MSTART),
		.mcand  ({2'b00, pred_q}),
		.mplier (skf_pkg::GAIN_ONE - gain_q),
		.res    (cov_res)
	);

	// Round both products by the gain fraction (floor of product plus half)
	assign est_lo_rnd = {1'b0, est_res.lo} + skf_pkg::RND_HALF;
	assign cov_lo_rnd = {1'b0, cov_res.lo} + skf_pkg::RND_HALF;
	assign delta      = {est_res.hi, 1'b0} + $signed({{(MW-1){1'b0}}, est_lo_rnd[GW:G]});
	assign cov_rnd    = {cov_res.hi, 1'b0} + $signed({{(MW-1){1'b0}}, cov_lo_rnd[GW:G]});

	// New estimate, clamped to the signed field range
	assign nx = {{4{est_q[DW-1]}}, est_q} + {delta[MW], delta};
	always_comb begin
		if (!nx[MW+1] && (|nx[MW:DW-1])) begin
			nx_sat = {1'b0, {(DW-1){1'b1}}};
		end else if (nx[MW+1] && !(&nx[MW:DW-1])) begin
			nx_sat = {1'b1, {(DW-1){1'b0}}};
		end else begin
			nx_sat = nx[DW-1:0];
		end
	end

	// New covariance, clamped to the unsigned field range
	assign cov_next = (|cov_rnd[MW:DW]) ? '1 : cov_rnd[DW-1:0];

	assign fin_go = (state_q == ST_FIN) & (~out_valid_q | out_ready);

	// Sequencer with state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			est_q       <= '0;
			cov_q       <= skf_pkg::COV_RESET;
		end else begin
			if (out_valid_q && out_ready && !fin_go) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_res.done) begin
						state_q <= ST_MSTART;
					end
				end
				ST_MSTART: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (est_res.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						est_q       <= nx_sat;
						cov_q       <= cov_next;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of one step
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pred_q  <= pred_sat;
			innov_q <= innov;
		end
		if (state_q == ST_PREP) begin
			zero_q <= (den == '0);
		end
		if ((state_q == ST_DIV) && div_res.done) begin
			if (zero_q || (div_res.quot > skf_pkg::GAIN_ONE)) begin
				gain_q <= skf_pkg::GAIN_ONE;
			end else begin
				gain_q <= div_res.quot;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign estimate_out = est_q;

endmodule
`default_nettype wire
